// ===== hw/rtl/ssu_pkg.sv =====
// shared types and constants for the surround upmixer
`default_nettype none

package ssu_pkg;

	// shared multiplier, accumulator, history, index and step widths
	localparam int MUL_W     = 32;
	localparam int PROD_W    = 64;
	localparam int ACC_W     = 68;
	localparam int HIST_W    = 32;
	localparam int CFG_IDX_W = 2;
	localparam int STEP_W    = 5;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_THRESH = 2'd2;

	// reset values and fixed gain, all q0.23
	localparam logic [22:0] GAIN_RST_Q23   = 23'd5292851;
	localparam logic [22:0] THRESH_RST_Q23 = 23'd8380219;
	localparam logic [22:0] STAGE2_GAIN    = 23'd6663308;
	localparam int          STAGE2_SHIFT   = 23;

	// 5 khz high-pass, q2.30
	localparam logic signed [MUL_W-1:0] HPF_B0 = 32'sd710028503;
	localparam logic signed [MUL_W-1:0] HPF_B1 = -32'sd1420057006;
	localparam logic signed [MUL_W-1:0] HPF_B2 = 32'sd710028503;
	localparam logic signed [MUL_W-1:0] HPF_A1 = -32'sd1256424982;
	localparam logic signed [MUL_W-1:0] HPF_A2 = 32'sd509947206;

	// 800 hz low-pass, q2.30
	localparam logic signed [MUL_W-1:0] LPF_B0 = 32'sd3214468;
	localparam logic signed [MUL_W-1:0] LPF_B1 = 32'sd6428936;
	localparam logic signed [MUL_W-1:0] LPF_B2 = 32'sd3214468;
	localparam logic signed [MUL_W-1:0] LPF_A1 = -32'sd1974736624;
	localparam logic signed [MUL_W-1:0] LPF_A2 = 32'sd913892098;

	// control for one multiply-accumulate operation
	typedef struct packed {
		logic issue;
		logic clr;
		logic sub;
	} mac_ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ssu_if.sv =====
// stream interfaces for stereo input and six-channel output
`default_nettype none

interface ssu_stereo_if #(
	parameter int SAMPLE_WIDTH = 24
);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] left_sample;
	logic signed [SAMPLE_WIDTH-1:0] right_sample;

	modport source (output valid, left_sample, right_sample, input ready);
	modport sink   (input valid, left_sample, right_sample, output ready);
endinterface

interface ssu_surround_if #(
	parameter int SAMPLE_WIDTH = 24
);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] left_out;
	logic signed [SAMPLE_WIDTH-1:0] right_out;
	logic signed [SAMPLE_WIDTH-1:0] center_out;
	logic signed [SAMPLE_WIDTH-1:0] lfe_out;
	logic signed [SAMPLE_WIDTH-1:0] left_surround_out;
	logic signed [SAMPLE_WIDTH-1:0] right_surround_out;

	modport source (
		output valid, left_out, right_out, center_out, lfe_out,
			left_surround_out, right_surround_out,
		input ready
	);
	modport sink (
		input valid, left_out, right_out, center_out, lfe_out,
			left_surround_out, right_surround_out,
		output ready
	);
endinterface

`default_nettype wire

// ===== hw/rtl/stereo_surround_upmixer_core.sv =====
// stereo to six-channel upmixer with one shared multiply-accumulate unit
//
//  channel    | role   | payload
//  -----------+--------+---------------------------------------------------
//  stereo     | sink   | left_sample, right_sample
//  surround   | source | left_out, right_out, center_out, lfe_out,
//             |        | left_surround_out, right_surround_out
//  cfg_*      | write  | cfg_wen, cfg_index, cfg_data (gain, mode, threshold)
//
// the sequencer takes no new pair until the last one has been delivered;
// 14 products go one after another through the single 32x32 multiplier,
// which has a product register and an accumulator behind it.
// arst_n resets the sequencer, output valid, config and both filter histories.
// stereo.ready is low while a pair is in work; a finished result waits in
// the output register and only its last step stalls if surround is not ready.
`default_nettype none

module stereo_surround_upmixer_core #(
	parameter int SAMPLE_WIDTH   = 24,
	parameter int COEF_FRAC_BITS = 30
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_wen,
	input  wire logic [ssu_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [SAMPLE_WIDTH-2:0]             cfg_data,
	ssu_stereo_if.sink                               stereo,
	ssu_surround_if.source                           surround
);
	import ssu_pkg::*;

	localparam int SW         = SAMPLE_WIDTH;
	localparam int F          = SAMPLE_WIDTH - 1;
	localparam int COEF_SHIFT = 30 - COEF_FRAC_BITS;

	// q0.23 constants rescaled to q0.F through a q0.32 intermediate
	localparam logic [F-1:0] GAIN_RST   = F'({GAIN_RST_Q23, 9'd0} >> (32 - F));
	localparam logic [F-1:0] THRESH_RST = F'({THRESH_RST_Q23, 9'd0} >> (32 - F));

	// coefficients at the chosen fraction width
	localparam logic signed [MUL_W-1:0] HB0 = HPF_B0 >>> COEF_SHIFT;
	localparam logic signed [MUL_W-1:0] HB1 = HPF_B1 >>> COEF_SHIFT;
	localparam logic signed [MUL_W-1:0] HB2 = HPF_B2 >>> COEF_SHIFT;
	localparam logic signed [MUL_W-1:0] HA1 = HPF_A1 >>> COEF_SHIFT;
	localparam logic signed [MUL_W-1:0] HA2 = HPF_A2 >>> COEF_SHIFT;
	localparam logic signed [MUL_W-1:0] LB0 = LPF_B0 >>> COEF_SHIFT;
	localparam logic signed [MUL_W-1:0] LB1 = LPF_B1 >>> COEF_SHIFT;
	localparam logic signed [MUL_W-1:0] LB2 = LPF_B2 >>> COEF_SHIFT;
	localparam logic signed [MUL_W-1:0] LA1 = LPF_A1 >>> COEF_SHIFT;
	localparam logic signed [MUL_W-1:0] LA2 = LPF_A2 >>> COEF_SHIFT;

	// sequencer steps; a product passes the product register and the accumulator before it is read
	localparam logic [STEP_W-1:0] ST_MUL_GL  = 5'd0;   // left times gain
	localparam logic [STEP_W-1:0] ST_MUL_GR  = 5'd1;   // right times gain
	localparam logic [STEP_W-1:0] ST_L       = 5'd2;   // capture gained left
	localparam logic [STEP_W-1:0] ST_R       = 5'd3;   // capture right, left times -2 db
	localparam logic [STEP_W-1:0] ST_MUL_KR  = 5'd4;   // right times -2 db
	localparam logic [STEP_W-1:0] ST_L2      = 5'd5;   // capture l2, high-pass b0
	localparam logic [STEP_W-1:0] ST_R2      = 5'd6;   // capture r2, high-pass b1
	localparam logic [STEP_W-1:0] ST_MIX     = 5'd7;   // centre and lfe input, b2
	localparam logic [STEP_W-1:0] ST_HA1     = 5'd8;
	localparam logic [STEP_W-1:0] ST_HA2     = 5'd9;
	localparam logic [STEP_W-1:0] ST_LB0     = 5'd10;  // low-pass b0
	localparam logic [STEP_W-1:0] ST_LS      = 5'd11;  // high-pass done, low-pass b1
	localparam logic [STEP_W-1:0] ST_LB2     = 5'd12;
	localparam logic [STEP_W-1:0] ST_LA1     = 5'd13;
	localparam logic [STEP_W-1:0] ST_LA2     = 5'd14;
	localparam logic [STEP_W-1:0] ST_DRAIN   = 5'd15;  // last product in flight
	localparam logic [STEP_W-1:0] ST_LFE     = 5'd16;  // low-pass done
	localparam logic [STEP_W-1:0] ST_DELIVER = 5'd17;  // load output register

	// configuration
	logic [F-1:0]  gain_q;
	logic [1:0]    mode_q;
	logic [F-1:0]  thr_q;

	// sequencer
	logic              busy_q;
	logic [STEP_W-1:0] step_q;
	logic              in_xfer;
	logic              deliver;

	// working values
	logic signed [SW-1:0] xl_q, xr_q;
	logic signed [SW-1:0] l_q, r_q, l2_q, r2_q;
	logic signed [SW-1:0] c_q, lfex_q, ls_q, lfe_q;
	logic signed [SW-1:0] ls_x;

	// filter histories
	logic signed [SW-1:0]     ls_xh0_q, ls_xh1_q, lfe_xh0_q, lfe_xh1_q;
	logic signed [HIST_W-1:0] ls_yh0_q, ls_yh1_q, lfe_yh0_q, lfe_yh1_q;

	// output register
	logic                 out_v_q;
	logic signed [SW-1:0] o_l_q, o_r_q, o_c_q, o_lfe_q, o_ls_q, o_rs_q;

	// shared unit
	mac_ctl_t                mac_ctl;
	logic signed [MUL_W-1:0] op_a, op_b;
	logic signed [ACC_W-1:0] acc;

	// biquad output rounding and saturation
	logic signed [ACC_W-1:0]  y_full;
	logic [ACC_W-HIST_W:0]    y_top_h;
	logic [ACC_W-F-1:0]       y_top_o;
	logic signed [HIST_W-1:0] y_hist;
	logic signed [SW-1:0]     y_out;

	// centre and lfe clip
	logic signed [SW:0] sum_lr, dif_lr, thr_pos, thr_neg;
	logic signed [SW-1:0] c_clip, d_clip;

	assign in_xfer      = stereo.valid && stereo.ready;
	assign stereo.ready = !busy_q;
	assign deliver      = busy_q && (step_q == ST_DELIVER) && (!out_v_q || surround.ready);
	assign ls_x         = -l_q;

	// operand selection per step
	always_comb begin
		op_a    = '0;
		op_b    = '0;
		mac_ctl = '0;
		case (step_q)
			ST_MUL_GL: begin
				op_a = MUL_W'(xl_q);
				op_b = MUL_W'(gain_q);
				mac_ctl.clr = 1'b1;
			end
			ST_MUL_GR: begin
				op_a = MUL_W'(xr_q);
				op_b = MUL_W'(gain_q);
				mac_ctl.clr = 1'b1;
			end
			ST_R: begin
				op_a = MUL_W'(l_q);
				op_b = MUL_W'(STAGE2_GAIN);
				mac_ctl.clr = 1'b1;
			end
			ST_MUL_KR: begin
				op_a = MUL_W'(r_q);
				op_b = MUL_W'(STAGE2_GAIN);
				mac_ctl.clr = 1'b1;
			end
			ST_L2: begin
				op_a = MUL_W'(ls_x);
				op_b = HB0;
				mac_ctl.clr = 1'b1;
			end
			ST_R2: begin
				op_a = MUL_W'(ls_xh0_q);
				op_b = HB1;
			end
			ST_MIX: begin
				op_a = MUL_W'(ls_xh1_q);
				op_b = HB2;
			end
			ST_HA1: begin
				op_a = ls_yh0_q;
				op_b = HA1;
				mac_ctl.sub = 1'b1;
			end
			ST_HA2: begin
				op_a = ls_yh1_q;
				op_b = HA2;
				mac_ctl.sub = 1'b1;
			end
			ST_LB0: begin
				op_a = MUL_W'(lfex_q);
				op_b = LB0;
				mac_ctl.clr = 1'b1;
			end
			ST_LS: begin
				op_a = MUL_W'(lfe_xh0_q);
				op_b = LB1;
			end
			ST_LB2: begin
				op_a = MUL_W'(lfe_xh1_q);
				op_b = LB2;
			end
			ST_LA1: begin
				op_a = lfe_yh0_q;
				op_b = LA1;
				mac_ctl.sub = 1'b1;
			end
			ST_LA2: begin
				op_a = lfe_yh1_q;
				op_b = LA2;
				mac_ctl.sub = 1'b1;
			end
			default: begin
				mac_ctl = '0;
			end
		endcase
		mac_ctl.issue = busy_q && (step_q <= ST_LA2);
	end

	ssu_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.op_a   (op_a),
		.op_b   (op_b),
		.acc    (acc)
	);

	// floor shift of the biquad sum, then saturate to history and sample range
	assign y_full  = acc >>> COEF_FRAC_BITS;
	assign y_top_h = y_full[ACC_W-1:HIST_W-1];
	assign y_top_o = y_full[ACC_W-1:F];

	always_comb begin
		if ((&y_top_h) || !(|y_top_h)) begin
			y_hist = y_full[HIST_W-1:0];
		end else begin
			y_hist = {y_full[ACC_W-1], {(HIST_W-1){!y_full[ACC_W-1]}}};
		end
		if ((&y_top_o) || !(|y_top_o)) begin
			y_out = y_full[SW-1:0];
		end else begin
			y_out = {y_full[ACC_W-1], {F{!y_full[ACC_W-1]}}};
		end
	end

	// clip sum and difference to +-threshold
	assign sum_lr  = {l2_q[SW-1], l2_q} + {r2_q[SW-1], r2_q};
	assign dif_lr  = {l2_q[SW-1], l2_q} - {r2_q[SW-1], r2_q};
	assign thr_pos = {2'b00, thr_q};
	assign thr_neg = -thr_pos;

	always_comb begin
		if (sum_lr > thr_pos) begin
			c_clip = thr_pos[SW-1:0];
		end else if (sum_lr < thr_neg) begin
			c_clip = thr_neg[SW-1:0];
		end else begin
			c_clip = sum_lr[SW-1:0];
		end
		if (dif_lr > thr_pos) begin
			d_clip = thr_pos[SW-1:0];
		end else if (dif_lr < thr_neg) begin
			d_clip = thr_neg[SW-1:0];
		end else begin
			d_clip = dif_lr[SW-1:0];
		end
	end

	// control, configuration and filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			step_q    <= ST_MUL_GL;
			out_v_q   <= 1'b0;
			gain_q    <= GAIN_RST;
			mode_q    <= 2'd0;
			thr_q     <= THRESH_RST;
			ls_xh0_q  <= '0;
			ls_xh1_q  <= '0;
			ls_yh0_q  <= '0;
			ls_yh1_q  <= '0;
			lfe_xh0_q <= '0;
			lfe_xh1_q <= '0;
			lfe_yh0_q <= '0;
			lfe_yh1_q <= '0;
		end else begin
			if (cfg_wen) begin
				case (cfg_index)
					REG_GAIN:   gain_q <= cfg_data;
					REG_MODE:   mode_q <= cfg_data[1:0];
					REG_THRESH: thr_q  <= cfg_data;
					default:    ;
				endcase
			end

			if (in_xfer) begin
				busy_q <= 1'b1;
				step_q <= ST_MUL_GL;
			end else if (busy_q) begin
				if (step_q != ST_DELIVER) begin
					step_q <= step_q + 1'b1;
				end else if (deliver) begin
					busy_q <= 1'b0;
				end
			end

			// high-pass history always advances
			if (busy_q && step_q == ST_LS) begin
				ls_xh1_q <= ls_xh0_q;
				ls_xh0_q <= ls_x;
				ls_yh1_q <= ls_yh0_q;
				ls_yh0_q <= y_hist;
			end

			// low-pass history only in lfe modes
			if (busy_q && step_q == ST_LFE && mode_q[0]) begin
				lfe_xh1_q <= lfe_xh0_q;
				lfe_xh0_q <= lfex_q;
				lfe_yh1_q <= lfe_yh0_q;
				lfe_yh0_q <= y_hist;
			end

			if (deliver) begin
				out_v_q <= 1'b1;
			end else if (surround.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// working values and output register
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			xl_q <= stereo.left_sample;
			xr_q <= stereo.right_sample;
		end
		if (busy_q) begin
			case (step_q)
				ST_L:   l_q  <= acc[F +: SW];
				ST_R:   r_q  <= acc[F +: SW];
				ST_L2:  l2_q <= acc[STAGE2_SHIFT +: SW];
				ST_R2:  r2_q <= acc[STAGE2_SHIFT +: SW];
				ST_MIX: begin
					c_q    <= mode_q[1] ? c_clip : '0;
					lfex_q <= d_clip;
				end
				ST_LS:  ls_q  <= y_out;
				ST_LFE: lfe_q <= mode_q[0] ? y_out : '0;
				default: ;
			endcase
		end
		if (deliver) begin
			o_l_q   <= l_q;
			o_r_q   <= r_q;
			o_c_q   <= c_q;
			o_lfe_q <= lfe_q;
			o_ls_q  <= ls_q;
			o_rs_q  <= -r_q;
		end
	end

	assign surround.valid              = out_v_q;
	assign surround.left_out           = o_l_q;
	assign surround.right_out          = o_r_q;
	assign surround.center_out         = o_c_q;
	assign surround.lfe_out            = o_lfe_q;
	assign surround.left_surround_out  = o_ls_q;
	assign surround.right_surround_out = o_rs_q;

endmodule

`default_nettype wire

// ===== hw/rtl/ssu_mac.sv =====
// shared multiplier with product register and accumulator
`default_nettype none

module ssu_mac (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire ssu_pkg::mac_ctl_t                  ctl,
	input  wire logic signed [ssu_pkg::MUL_W-1:0]   op_a,
	input  wire logic signed [ssu_pkg::MUL_W-1:0]   op_b,
	output logic signed [ssu_pkg::ACC_W-1:0]        acc
);
	import ssu_pkg::*;

	logic signed [PROD_W-1:0] prod_s1;
	mac_ctl_t                 ctl_s1;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  base;
	logic signed [ACC_W-1:0]  prod_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= ctl;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= op_a * op_b;
	end

	assign base     = ctl_s1.clr ? '0 : acc_q;
	assign prod_ext = ACC_W'(prod_s1);

	always_ff @(posedge clk) begin
		if (ctl_s1.issue) begin
			acc_q <= ctl_s1.sub ? (base - prod_ext) : (base + prod_ext);
		end
	end

	assign acc = acc_q;

endmodule

`default_nettype wire
